@@ rtl/core/sds_pkg.sv @@
// Shared types and constants for the scroll delta smoother.
package sds_pkg;

   // Request codes carried in req_type
   localparam logic [1:0] ReqFeed  = 2'd0;
   localparam logic [1:0] ReqTick  = 2'd1;
   localparam logic [1:0] ReqClear = 2'd2;

   // Configuration register indexes
   localparam int unsigned CsrIdxW = 2;
   localparam logic [CsrIdxW-1:0] CsrDrainSteps    = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrIntervalTicks = 2'd1;

   // Field widths
   localparam int unsigned DeltaW    = 16;
   localparam int unsigned AccW      = 32;
   localparam int unsigned MagW      = AccW - 1;
   localparam int unsigned StepsW    = 8;
   localparam int unsigned IntervalW = 10;
   localparam int unsigned CsrDataW  = IntervalW;

   // Divider step count and its counter width
   localparam int unsigned DivSteps = MagW;
   localparam int unsigned DivCntW  = $clog2(DivSteps);

   // Saturation limit, +/-(2^31-1)
   localparam logic signed [AccW:0] AccMax = {2'b00, {(AccW-1){1'b1}}};
   localparam logic signed [AccW:0] AccMin = -AccMax;

   // Divider command
   typedef struct packed {
      logic              start;
      logic [MagW-1:0]   dividend;
      logic [StepsW-1:0] divisor;
   } sds_div_req_type;

   // Divider status
   typedef struct packed {
      logic            busy;
      logic            done;
      logic [MagW-1:0] quotient;
   } sds_div_rsp_type;

endpackage

@@ rtl/core/sds_if.sv @@
// Channel interfaces of the scroll delta smoother: request, response, register write.
interface sds_req_if import sds_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               req_type;
   logic signed [DeltaW-1:0] scroll_delta;

   modport source (output valid, req_type, scroll_delta, input ready);
   modport sink   (input valid, req_type, scroll_delta, output ready);
endinterface

interface sds_rsp_if import sds_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic signed [AccW-1:0] chunk;
   logic signed [AccW-1:0] remaining;

   modport source (output valid, chunk, remaining, input ready);
   modport sink   (input valid, chunk, remaining, output ready);
endinterface

interface sds_csr_if import sds_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/sds_divider.sv @@
// Bit-serial restoring divider: 31-bit magnitude by 8-bit step count.
module sds_divider import sds_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  sds_div_req_type div_req,
   output sds_div_rsp_type div_rsp
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DivCntW-1:0]  count_ff, count_in;
   logic [StepsW-1:0]   rem_ff, rem_in;
   logic [StepsW-1:0]   divisor_ff, divisor_in;
   logic [MagW-1:0]     quot_ff, quot_in;
   logic [StepsW:0]     trial;
   logic [StepsW:0]     diff;

   // One quotient bit per cycle; dividend shifts out as quotient shifts in
   always_comb begin
      trial      = {rem_ff, quot_ff[MagW-1]};
      diff       = trial - {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quot_in    = quot_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = DivCntW'(DivSteps - 1);
         rem_in     = '0;
         divisor_in = div_req.divisor;
         quot_in    = div_req.dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in  = diff[StepsW-1:0];
            quot_in = {quot_ff[MagW-2:0], 1'b1};
         end else begin
            rem_in  = trial[StepsW-1:0];
            quot_in = {quot_ff[MagW-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

@@ rtl/core/scroll_delta_smoother.sv @@
// Top level of the scroll delta smoother: accumulator, drain sequencer, registers.
//
// Requests arrive on req_bus: feed a signed delta, one time tick, or clear.
// Feeds add into a 32-bit accumulator that saturates at +/-(2^31-1).
// A feed while idle, and the last tick of an interval while draining,
// release one chunk: |accumulator| / drain_steps (at least 1) with the
// accumulator's sign. The chunk and what is left appear on rsp_bus.
// Registers are written on csr_bus (index 0 drain_steps, 1 interval_ticks;
// a zero write is stored as one); csr_bus is always ready.
// Timing: a request that releases a chunk starts the divider, which runs
// its 31 steps and raises done; the sequencer then emits the chunk into
// the response register. req_bus is not ready while a division runs or
// while its chunk waits to be emitted, and is ready again after the emit.
// The response sits in an output register, so a new request is taken while
// a result waits; if the receiver stalls and the next chunk is ready, the
// block holds it until the output register frees.
// Reset (synchronous, active high) clears the accumulator, drain state,
// countdown and response valid, and sets both registers to one.
module scroll_delta_smoother import sds_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sds_req_if.sink    req_bus,
   sds_rsp_if.source  rsp_bus,
   sds_csr_if.sink    csr_bus
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_DIV  = 3'b010,
      S_EMIT = 3'b100
   } sds_state_type;

   sds_state_type          state_ff, state_in;
   logic signed [AccW-1:0] acc_ff, acc_in;
   logic                   draining_ff, draining_in;
   logic [IntervalW-1:0]   cd_ff, cd_in;
   logic [StepsW-1:0]      steps_ff, steps_in;
   logic [IntervalW-1:0]   interval_ff, interval_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [AccW-1:0] rsp_chunk_ff, rsp_chunk_in;
   logic signed [AccW-1:0] rsp_remaining_ff, rsp_remaining_in;

   sds_div_req_type        div_req;
   sds_div_rsp_type        div_rsp;

   logic                   req_xfer;
   logic                   emit_go;
   logic signed [AccW:0]   sum;
   logic signed [AccW-1:0] acc_sat;
   logic signed [AccW-1:0] acc_abs;
   logic [MagW-1:0]        part;
   logic signed [AccW-1:0] chunk_val;

   sds_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // Saturating add of the incoming delta
   always_comb begin
      sum = {acc_ff[AccW-1], acc_ff} + {{(AccW+1-DeltaW){req_bus.scroll_delta[DeltaW-1]}},
                                         req_bus.scroll_delta};
      if (sum > AccMax) begin
         acc_sat = AccMax[AccW-1:0];
      end else if (sum < AccMin) begin
         acc_sat = AccMin[AccW-1:0];
      end else begin
         acc_sat = sum[AccW-1:0];
      end
   end

   // Chunk from the quotient, at least one, with the accumulator's sign
   assign part      = (div_rsp.quotient == '0) ? MagW'(1) : div_rsp.quotient;
   assign chunk_val = acc_ff[AccW-1] ? -$signed({1'b0, part}) : $signed({1'b0, part});
   assign emit_go   = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_bus.ready);

   // Request decode and drain sequencer
   always_comb begin
      state_in         = state_ff;
      acc_in           = acc_ff;
      draining_in      = draining_ff;
      cd_in            = cd_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_chunk_in     = rsp_chunk_ff;
      rsp_remaining_in = rsp_remaining_ff;
      div_req.start    = 1'b0;
      acc_abs          = '0;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (req_bus.req_type)
                  ReqFeed: begin
                     acc_in = acc_sat;
                     if (!draining_ff && acc_sat != '0) begin
                        div_req.start = 1'b1;
                        state_in      = S_DIV;
                     end
                  end
                  ReqTick: begin
                     if (draining_ff) begin
                        if (cd_ff > IntervalW'(1)) begin
                           cd_in = cd_ff - 1'b1;
                        end else begin
                           cd_in = '0;
                           if (acc_ff != '0) begin
                              div_req.start = 1'b1;
                              state_in      = S_DIV;
                           end else begin
                              draining_in = 1'b0;
                           end
                        end
                     end
                  end
                  ReqClear: begin
                     acc_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_go) begin
               acc_in           = acc_ff - chunk_val;
               rsp_valid_in     = 1'b1;
               rsp_chunk_in     = chunk_val;
               rsp_remaining_in = acc_ff - chunk_val;
               if (acc_ff != chunk_val) begin
                  draining_in = 1'b1;
                  cd_in       = interval_ff;
               end else begin
                  draining_in = 1'b0;
                  cd_in       = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Divider operand is the magnitude of the value being drained
      acc_abs          = acc_in[AccW-1] ? -acc_in : acc_in;
      div_req.dividend = acc_abs[MagW-1:0];
      div_req.divisor  = steps_ff;
   end

   // Register writes, zero stored as one
   always_comb begin
      steps_in    = steps_ff;
      interval_in = interval_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            CsrDrainSteps: begin
               steps_in = (csr_bus.data[StepsW-1:0] == '0) ? StepsW'(1)
                                                           : csr_bus.data[StepsW-1:0];
            end
            CsrIntervalTicks: begin
               interval_in = (csr_bus.data == '0) ? IntervalW'(1) : csr_bus.data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         acc_ff       <= '0;
         draining_ff  <= 1'b0;
         cd_ff        <= '0;
         steps_ff     <= StepsW'(1);
         interval_ff  <= IntervalW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         draining_ff  <= draining_in;
         cd_ff        <= cd_in;
         steps_ff     <= steps_in;
         interval_ff  <= interval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_chunk_ff     <= rsp_chunk_in;
      rsp_remaining_ff <= rsp_remaining_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.chunk     = rsp_chunk_ff;
   assign rsp_bus.remaining = rsp_remaining_ff;

   // Requests are only taken with the divider at rest
   a_idle_div_rest: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !div_rsp.busy)
      else $error("divider busy while accepting requests");

   // Divider finishes only while the sequencer waits for it
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV))
      else $error("divider done outside the divide state");

   // Reported remainder matches the accumulator after an emit
   a_remaining_match: assert property (@(posedge clock) disable iff (reset)
      emit_go |=> (rsp_remaining_ff == acc_ff))
      else $error("remaining differs from accumulator");

   // Idle means no countdown under way
   a_idle_cd_zero: assert property (@(posedge clock) disable iff (reset)
      !draining_ff |-> (cd_ff == '0))
      else $error("countdown nonzero while idle");

   // Saturation never reaches the most negative code
   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      acc_ff != $signed({1'b1, {(AccW-1){1'b0}}}))
      else $error("accumulator out of range");

endmodule
